// ===== rtl/sas_pkg.sv =====
// Shared constants and codes for the sprite animation sequencer.
`default_nettype none
package sas_pkg;

  localparam int NUM_SLOTS       = 16;
  localparam int NUM_DEFS        = 16;
  localparam int MAX_FRAME_SLOTS = 16;
  localparam int TIME_BITS       = 16;

  localparam int CMD_W   = 3;
  localparam int ID_W    = 4;
  localparam int FRAME_W = 4;
  localparam int SHEET_W = 8;
  localparam int STAT_W  = 2;

  localparam int STORE_DEPTH = NUM_DEFS * MAX_FRAME_SLOTS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  // frame record: duration, row, column
  localparam int REC_W       = TIME_BITS + 2 * SHEET_W;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

  localparam logic [STAT_W-1:0] STS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STS_BAD_ID    = 2'd2;
  localparam logic [STAT_W-1:0] STS_BAD_COUNT = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/sas_req_if.sv =====
// Request channel interface of the sprite animation sequencer.
`default_nettype none
interface sas_req_if;
  import sas_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [TIME_BITS-1:0] dt;
  logic [ID_W-1:0]      def_id;
  logic [ID_W-1:0]      slot;
  logic [FRAME_W-1:0]   frame_number;
  logic [SHEET_W-1:0]   sheet_col;
  logic [SHEET_W-1:0]   sheet_row;
  logic [TIME_BITS-1:0] frame_time;
  logic [FRAME_W-1:0]   frame_total;
  logic                 looping;

  modport source (
    output valid, cmd, dt, def_id, slot, frame_number, sheet_col, sheet_row,
           frame_time, frame_total, looping,
    input  ready
  );
  modport sink (
    input  valid, cmd, dt, def_id, slot, frame_number, sheet_col, sheet_row,
           frame_time, frame_total, looping,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/sas_rsp_if.sv =====
// Response channel interface of the sprite animation sequencer.
`default_nettype none
interface sas_rsp_if;
  import sas_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    slot_id;
  logic               is_active;
  logic [SHEET_W-1:0] cur_row;
  logic [SHEET_W-1:0] cur_col;
  logic [FRAME_W-1:0] cur_frame;

  modport source (
    output valid, status, slot_id, is_active, cur_row, cur_col, cur_frame,
    input  ready
  );
  modport sink (
    input  valid, status, slot_id, is_active, cur_row, cur_col, cur_frame,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/sas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/sprite_animation_sequencer.sv =====
// Sprite animation sequencer: slot table, frame store and command sequencer.
// Every request passes through the result state before its response loads; create scans
// the slots in order for a free one, and tick steps each slot in turn through the
// shared subtract/compare unit, plus a frame-store read state per advancing slot.
// One request in flight; the next is accepted the cycle after its response loads.
// Synchronous reset clears the slot table and frame counts; frame store is not cleared.
`default_nettype none
module sprite_animation_sequencer (
  input  wire logic clk,
  input  wire logic rst,
  sas_req_if.sink   req,
  sas_rsp_if.source rsp
);
  import sas_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_TICK   = 7'b0000010,
    ST_TLOAD  = 7'b0000100,
    ST_CREATE = 7'b0001000,
    ST_QRD    = 7'b0010000,
    ST_QDATA  = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  localparam logic [ID_W-1:0] LAST_SLOT = ID_W'(NUM_SLOTS - 1);

  state_t state;

  logic                 slot_active [NUM_SLOTS];
  logic [ID_W-1:0]      slot_def    [NUM_SLOTS];
  logic                 slot_loop   [NUM_SLOTS];
  logic [FRAME_W-1:0]   slot_frame  [NUM_SLOTS];
  logic [TIME_BITS-1:0] slot_rem    [NUM_SLOTS];
  logic [FRAME_W-1:0]   def_cnt     [NUM_DEFS];

  logic [ID_W-1:0]      idx;
  logic [TIME_BITS-1:0] dt_r;
  logic [ID_W-1:0]      def_r;
  logic                 loop_r;

  logic [STAT_W-1:0]  res_status;
  logic [ID_W-1:0]    res_slot_id;
  logic               res_active;
  logic [SHEET_W-1:0] res_row;
  logic [SHEET_W-1:0] res_col;
  logic [FRAME_W-1:0] res_frame;

  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [ID_W-1:0]    out_slot_id;
  logic               out_active;
  logic [SHEET_W-1:0] out_row;
  logic [SHEET_W-1:0] out_col;
  logic [FRAME_W-1:0] out_frame;

  logic                 accept;
  logic                 def_bad;
  logic                 slot_bad;
  logic                 total_bad;
  logic [ID_W-1:0]      cnt_addr;
  logic [FRAME_W-1:0]   cnt_rd;
  logic [FRAME_W-1:0]   cnt_eff;
  logic [FRAME_W:0]     frame_inc;
  logic [FRAME_W-1:0]   next_frame;
  logic [TIME_BITS:0]   diff;
  logic                 keep;
  logic [FRAME_W-1:0]   rd_frame;
  logic                 ram_we;
  logic [STORE_AW-1:0]  ram_waddr;
  logic [REC_W-1:0]     ram_wdata;
  logic [STORE_AW-1:0]  ram_raddr;
  logic [REC_W-1:0]     ram_rdata;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  assign def_bad   = {1'b0, req.def_id} >= (ID_W + 1)'(NUM_DEFS);
  assign slot_bad  = {1'b0, req.slot} >= (ID_W + 1)'(NUM_SLOTS);
  assign total_bad = (req.frame_total == '0)
                  || ({1'b0, req.frame_total} >= (FRAME_W + 1)'(MAX_FRAME_SLOTS))
                  || (req.frame_number >= req.frame_total);

  // frame count lookup: per-slot definition during a tick, request otherwise
  assign cnt_addr = (state == ST_TICK) ? slot_def[idx] : req.def_id;
  assign cnt_rd   = def_cnt[cnt_addr];
  assign cnt_eff  = (cnt_rd == '0) ? FRAME_W'(1) : cnt_rd;

  assign frame_inc  = {1'b0, slot_frame[idx]} + (FRAME_W + 1)'(1);
  assign next_frame = (frame_inc >= {1'b0, cnt_eff})
                    ? (slot_loop[idx] ? '0 : cnt_eff - FRAME_W'(1))
                    : frame_inc[FRAME_W-1:0];

  // shared subtract/compare unit: remaining time stays only while rem > dt
  assign diff = {1'b0, slot_rem[idx]} - {1'b0, dt_r};
  assign keep = !diff[TIME_BITS] && (diff[TIME_BITS-1:0] != '0);

  assign rd_frame  = (state == ST_TICK) ? next_frame : slot_frame[idx];
  assign ram_raddr = {slot_def[idx], rd_frame};

  assign ram_we    = accept && (req.cmd == CMD_WRITE) && !def_bad && !total_bad;
  assign ram_waddr = {req.def_id, req.frame_number};
  assign ram_wdata = {req.frame_time, req.sheet_row, req.sheet_col};

  sas_ram #(
    .WIDTH (REC_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_active[i] <= 1'b0;
        slot_def[i]    <= '0;
        slot_loop[i]   <= 1'b0;
        slot_frame[i]  <= '0;
        slot_rem[i]    <= '0;
      end
      for (int d = 0; d < NUM_DEFS; d++) begin
        def_cnt[d] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_slot_id <= '0;
            res_active  <= 1'b0;
            res_row     <= '0;
            res_col     <= '0;
            res_frame   <= '0;
            dt_r        <= req.dt;
            def_r       <= req.def_id;
            loop_r      <= req.looping;
            case (req.cmd)
              CMD_TICK: begin
                res_status <= STS_OK;
                idx        <= '0;
                state      <= ST_TICK;
              end
              CMD_WRITE: begin
                state <= ST_RESULT;
                if (def_bad) begin
                  res_status <= STS_BAD_ID;
                end else if (total_bad) begin
                  res_status <= STS_BAD_COUNT;
                end else begin
                  res_status          <= STS_OK;
                  def_cnt[req.def_id] <= req.frame_total;
                end
              end
              CMD_CREATE: begin
                if (def_bad) begin
                  res_status <= STS_BAD_ID;
                  state      <= ST_RESULT;
                end else if (cnt_rd == '0) begin
                  res_status <= STS_BAD_COUNT;
                  state      <= ST_RESULT;
                end else begin
                  res_status <= STS_OK;
                  idx        <= '0;
                  state      <= ST_CREATE;
                end
              end
              CMD_DESTROY: begin
                state <= ST_RESULT;
                if (slot_bad) begin
                  res_status <= STS_BAD_ID;
                end else begin
                  res_status            <= STS_OK;
                  slot_active[req.slot] <= 1'b0;
                end
              end
              CMD_QUERY: begin
                if (slot_bad) begin
                  res_status <= STS_BAD_ID;
                  state      <= ST_RESULT;
                end else begin
                  res_status <= STS_OK;
                  idx        <= req.slot;
                  state      <= ST_QRD;
                end
              end
              default: begin
                res_status <= STS_OK;
                state      <= ST_RESULT;
              end
            endcase
          end
        end
        ST_TICK: begin
          if (slot_active[idx] && !keep) begin
            // advance: frame store read for the new duration is in flight
            slot_frame[idx] <= next_frame;
            state           <= ST_TLOAD;
          end else begin
            if (slot_active[idx]) begin
              slot_rem[idx] <= diff[TIME_BITS-1:0];
            end
            if (idx == LAST_SLOT) begin
              state <= ST_RESULT;
            end else begin
              idx <= idx + ID_W'(1);
            end
          end
        end
        ST_TLOAD: begin
          slot_rem[idx] <= ram_rdata[REC_W-1 -: TIME_BITS];
          if (idx == LAST_SLOT) begin
            state <= ST_RESULT;
          end else begin
            idx   <= idx + ID_W'(1);
            state <= ST_TICK;
          end
        end
        ST_CREATE: begin
          if (!slot_active[idx]) begin
            slot_active[idx] <= 1'b1;
            slot_def[idx]    <= def_r;
            slot_loop[idx]   <= loop_r;
            slot_frame[idx]  <= '0;
            slot_rem[idx]    <= '0;
            res_slot_id      <= idx;
            state            <= ST_RESULT;
          end else if (idx == LAST_SLOT) begin
            res_status <= STS_FULL;
            state      <= ST_RESULT;
          end else begin
            idx <= idx + ID_W'(1);
          end
        end
        ST_QRD: begin
          state <= slot_active[idx] ? ST_QDATA : ST_RESULT;
        end
        ST_QDATA: begin
          res_active <= 1'b1;
          res_col    <= ram_rdata[SHEET_W-1:0];
          res_row    <= ram_rdata[2*SHEET_W-1:SHEET_W];
          res_frame  <= slot_frame[idx];
          state      <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid || rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESULT && (!out_valid || rsp.ready)) begin
      out_valid   <= 1'b1;
      out_status  <= res_status;
      out_slot_id <= res_slot_id;
      out_active  <= res_active;
      out_row     <= res_row;
      out_col     <= res_col;
      out_frame   <= res_frame;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.slot_id   = out_slot_id;
  assign rsp.is_active = out_active;
  assign rsp.cur_row   = out_row;
  assign rsp.cur_col   = out_col;
  assign rsp.cur_frame = out_frame;

  a_tload_after_tick: assert property (@(posedge clk) disable iff (rst)
    state == ST_TLOAD |-> $past(state) == ST_TICK)
    else $error("frame reload without a tick advance");

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESULT)
    else $error("response raised outside the result state");

  a_create_sets_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CREATE && !slot_active[idx]) |=> slot_active[$past(idx)])
    else $error("created slot not marked active");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the sprite animation sequencer.
`timescale 1ns / 1ps
module testbench;
  import sas_pkg::*;

  // command codes the block has no use for
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [TIME_BITS-1:0] dt;
    logic [ID_W-1:0]      def_id;
    logic [ID_W-1:0]      slot;
    logic [FRAME_W-1:0]   frame_number;
    logic [SHEET_W-1:0]   sheet_col;
    logic [SHEET_W-1:0]   sheet_row;
    logic [TIME_BITS-1:0] frame_time;
    logic [FRAME_W-1:0]   frame_total;
    logic                 looping;
  } anim_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    slot_id;
    logic               is_active;
    logic [SHEET_W-1:0] cur_row;
    logic [SHEET_W-1:0] cur_col;
    logic [FRAME_W-1:0] cur_frame;
  } anim_rsp_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] dur;
    logic [SHEET_W-1:0]   row;
    logic [SHEET_W-1:0]   col;
  } frame_rec_t;

  logic clk;
  logic rst;
  bit   idle_on;
  bit   rx_hold;
  int   rx_stall;
  int   n_err;

  sas_req_if req_ch ();
  sas_rsp_if rsp_ch ();

  sprite_animation_sequencer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Predicted sequencer state
  frame_rec_t                  frame_mem  [STORE_DEPTH];
  bit                          frame_set  [STORE_DEPTH];
  bit [FRAME_W-1:0]            def_count  [NUM_DEFS];
  bit                          slot_on    [NUM_SLOTS];
  bit [ID_W-1:0]               slot_def   [NUM_SLOTS];
  bit                          slot_loop  [NUM_SLOTS];
  bit [FRAME_W-1:0]            slot_frame [NUM_SLOTS];
  bit signed [TIME_BITS+1:0]   slot_left  [NUM_SLOTS];

  anim_rsp_t exp_rsp_q [$];

  function automatic int rec_index(int d, int f);
    return d * MAX_FRAME_SLOTS + f;
  endfunction

  // frame a slot moves to once its time runs out
  function automatic logic [FRAME_W-1:0] next_frame(int s);
    int cnt;
    int nxt;
    cnt = (def_count[slot_def[s]] == 0) ? 1 : def_count[slot_def[s]];
    nxt = slot_frame[s] + 1;
    if (nxt >= cnt) nxt = slot_loop[s] ? 0 : cnt - 1;
    return nxt[FRAME_W-1:0];
  endfunction

  function automatic anim_rsp_t sequence_cmd(anim_cmd_t r);
    anim_rsp_t  o;
    frame_rec_t rec;
    int         s;
    int         idx;
    o = '0;
    case (r.cmd)
      CMD_TICK: begin
        for (s = 0; s < NUM_SLOTS; s++) begin
          if (slot_on[s]) begin
            slot_left[s] = slot_left[s] - $signed({2'b00, r.dt});
            if (slot_left[s] <= 0) begin
              slot_frame[s] = next_frame(s);
              rec = frame_mem[rec_index(slot_def[s], slot_frame[s])];
              slot_left[s] = $signed({2'b00, rec.dur});
            end
          end
        end
      end
      CMD_WRITE: begin
        if (r.def_id >= NUM_DEFS) begin
          o.status = STS_BAD_ID;
        end else if (r.frame_total == 0 || r.frame_total >= MAX_FRAME_SLOTS ||
                     r.frame_number >= r.frame_total) begin
          o.status = STS_BAD_COUNT;
        end else begin
          idx = rec_index(r.def_id, r.frame_number);
          frame_mem[idx] = {r.frame_time, r.sheet_row, r.sheet_col};
          frame_set[idx] = 1'b1;
          def_count[r.def_id] = r.frame_total;
        end
      end
      CMD_CREATE: begin
        if (r.def_id >= NUM_DEFS) begin
          o.status = STS_BAD_ID;
        end else if (def_count[r.def_id] == 0) begin
          o.status = STS_BAD_COUNT;
        end else begin
          o.status = STS_FULL;
          for (s = 0; s < NUM_SLOTS && o.status == STS_FULL; s++) begin
            if (!slot_on[s]) begin
              slot_on[s]    = 1'b1;
              slot_def[s]   = r.def_id;
              slot_loop[s]  = r.looping;
              slot_frame[s] = '0;
              slot_left[s]  = '0;
              o.slot_id     = s[ID_W-1:0];
              o.status      = STS_OK;
            end
          end
        end
      end
      CMD_DESTROY: begin
        slot_on[r.slot] = 1'b0;
      end
      CMD_QUERY: begin
        if (slot_on[r.slot]) begin
          rec         = frame_mem[rec_index(slot_def[r.slot], slot_frame[r.slot])];
          o.is_active = 1'b1;
          o.cur_row   = rec.row;
          o.cur_col   = rec.col;
          o.cur_frame = slot_frame[r.slot];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Store entry that the request would read before it was ever written, or -1.
  function automatic int unwritten_read(anim_cmd_t r);
    bit signed [TIME_BITS+1:0] left;
    int s;
    int idx;
    if (r.cmd == CMD_QUERY && slot_on[r.slot]) begin
      idx = rec_index(slot_def[r.slot], slot_frame[r.slot]);
      if (!frame_set[idx]) return idx;
    end else if (r.cmd == CMD_TICK) begin
      for (s = 0; s < NUM_SLOTS; s++) begin
        left = slot_left[s] - $signed({2'b00, r.dt});
        idx  = rec_index(slot_def[s], next_frame(s));
        if (slot_on[s] && left <= 0 && !frame_set[idx]) return idx;
      end
    end
    return -1;
  endfunction

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return TIME_BITS'($urandom_range(0, 65535));
      default: return TIME_BITS'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic anim_cmd_t base_req();
    anim_cmd_t   r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    r   = raw[$bits(anim_cmd_t)-1:0];
    return r;
  endfunction

  function automatic anim_cmd_t tick_req(logic [TIME_BITS-1:0] dt);
    anim_cmd_t r;
    r     = base_req();
    r.cmd = CMD_TICK;
    r.dt  = dt;
    return r;
  endfunction

  function automatic anim_cmd_t write_req(int d, int f, int total, logic [SHEET_W-1:0] col,
                                          logic [SHEET_W-1:0] row,
                                          logic [TIME_BITS-1:0] ftime);
    anim_cmd_t r;
    r              = base_req();
    r.cmd          = CMD_WRITE;
    r.def_id       = d[ID_W-1:0];
    r.frame_number = f[FRAME_W-1:0];
    r.frame_total  = total[FRAME_W-1:0];
    r.sheet_col    = col;
    r.sheet_row    = row;
    r.frame_time   = ftime;
    return r;
  endfunction

  function automatic anim_cmd_t create_req(int d, logic loop);
    anim_cmd_t r;
    r         = base_req();
    r.cmd     = CMD_CREATE;
    r.def_id  = d[ID_W-1:0];
    r.looping = loop;
    return r;
  endfunction

  function automatic anim_cmd_t slot_req(logic [CMD_W-1:0] cmd, int s);
    anim_cmd_t r;
    r      = base_req();
    r.cmd  = cmd;
    r.slot = s[ID_W-1:0];
    return r;
  endfunction

  // mostly a running slot, sometimes any slot
  function automatic int pick_slot();
    int on_list [$];
    int s;
    for (s = 0; s < NUM_SLOTS; s++) if (slot_on[s]) on_list.push_back(s);
    if (on_list.size() == 0 || $urandom_range(0, 3) == 0) return $urandom_range(0, NUM_SLOTS-1);
    return on_list[$urandom_range(0, on_list.size()-1)];
  endfunction

  function automatic int pick_def();
    int d;
    int k;
    d = $urandom_range(0, NUM_DEFS-1);
    if ($urandom_range(0, 4) == 0) return d;
    for (k = 0; k < NUM_DEFS; k++)
      if (def_count[(d + k) % NUM_DEFS] != 0) return (d + k) % NUM_DEFS;
    return d;
  endfunction

  function automatic anim_cmd_t random_cmd(int sel);
    int d;
    int n;
    if (sel < 36) return tick_req(rand_time());
    if (sel < 48) begin
      d = $urandom_range(0, NUM_DEFS-1);
      n = (def_count[d] != 0 && $urandom_range(0, 9) < 7) ? def_count[d] :
          $urandom_range(1, MAX_FRAME_SLOTS-1);
      return write_req(d, $urandom_range(0, n-1), n, SHEET_W'($urandom), SHEET_W'($urandom),
                       rand_time());
    end
    if (sel < 60) return create_req(pick_def(), 1'($urandom));
    if (sel < 70) return slot_req(CMD_DESTROY, pick_slot());
    if (sel < 92) return slot_req(CMD_QUERY, pick_slot());
    return base_req();
  endfunction

  task automatic send_req(anim_cmd_t r);
    int gap;
    gap = (idle_on && $urandom_range(0, 1) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= r.cmd;
    req_ch.dt           <= r.dt;
    req_ch.def_id       <= r.def_id;
    req_ch.slot         <= r.slot;
    req_ch.frame_number <= r.frame_number;
    req_ch.sheet_col    <= r.sheet_col;
    req_ch.sheet_row    <= r.sheet_row;
    req_ch.frame_time   <= r.frame_time;
    req_ch.frame_total  <= r.frame_total;
    req_ch.looping      <= r.looping;
    do @(posedge clk); while (!req_ch.ready);
    exp_rsp_q.push_back(sequence_cmd(r));
  endtask

  // Writes any frame the request would read before it goes out.
  task automatic issue(anim_cmd_t r);
    int miss;
    int d;
    int f;
    miss = unwritten_read(r);
    while (miss >= 0) begin
      d = miss / MAX_FRAME_SLOTS;
      f = miss % MAX_FRAME_SLOTS;
      send_req(write_req(d, f, (def_count[d] > f) ? def_count[d] : f + 1,
                         SHEET_W'($urandom), SHEET_W'($urandom), rand_time()));
      miss = unwritten_read(r);
    end
    send_req(r);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (exp_rsp_q.size() != 0);
  endtask

  task automatic test_idle_table();
    anim_cmd_t r;
    issue(slot_req(CMD_QUERY, 0));
    issue(slot_req(CMD_QUERY, NUM_SLOTS-1));
    issue(create_req(3, 1'b1));           // definition has no frames yet
    issue(slot_req(CMD_DESTROY, 7));      // inactive slot, no effect
    issue(tick_req('1));
    r = base_req();
    r.cmd = CMD_SPARE5;
    issue(r);
    r = base_req();
    r.cmd = CMD_SPARE6;
    issue(r);
    r = base_req();
    r.cmd = CMD_SPARE7;
    issue(r);
  endtask

  task automatic test_frame_writes();
    issue(write_req(2, 0, 0, SHEET_W'($urandom), SHEET_W'($urandom), TIME_BITS'($urandom)));
    issue(write_req(2, 15, 15, SHEET_W'($urandom), SHEET_W'($urandom), TIME_BITS'($urandom)));
    issue(write_req(NUM_DEFS-1, MAX_FRAME_SLOTS-2, MAX_FRAME_SLOTS-1, '1, '1, '1));
    issue(write_req(0, 0, 2, '0, '0, 16'd3));
    issue(write_req(0, 1, 2, 8'hA5, 8'h5A, 16'd1));
  endtask

  task automatic test_slot_play();
    issue(create_req(0, 1'b1));
    issue(create_req(0, 1'b0));
    issue(slot_req(CMD_QUERY, 0));
    issue(tick_req('0));                  // fresh slots advance on the first tick
    issue(tick_req(16'd1));
    issue(slot_req(CMD_QUERY, 0));
    issue(slot_req(CMD_QUERY, 1));
    // shrink the definition under both running slots
    issue(write_req(0, 0, 1, 8'h3C, 8'hC3, 16'd2));
    issue(tick_req('1));
    issue(slot_req(CMD_QUERY, 1));
    issue(slot_req(CMD_DESTROY, 0));
    issue(slot_req(CMD_QUERY, 0));
  endtask

  task automatic test_table_full();
    int s;
    for (s = 0; s < NUM_SLOTS; s++)
      if (!slot_on[s]) issue(create_req(s[0] ? NUM_DEFS-1 : 0, s[1]));
    issue(create_req(0, 1'b1));
    issue(slot_req(CMD_QUERY, NUM_SLOTS-1));
    issue(slot_req(CMD_DESTROY, 9));
    issue(create_req(NUM_DEFS-1, 1'b0));
  endtask

  task automatic test_random(int n_items);
    int sent;
    int k;
    int d;
    int n;
    int sel;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        // lay down a whole animation, now and then a long one
        d = $urandom_range(0, NUM_DEFS-1);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, MAX_FRAME_SLOTS-1) :
            $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          issue(write_req(d, k, n, SHEET_W'($urandom), SHEET_W'($urandom), rand_time()));
        sent += n;
      end else begin
        issue(random_cmd(sel));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    int k;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        for (k = 0; k < 40; k++) issue(random_cmd($urandom_range(0, 99)));
        wait_drained();
      end
    join
  endtask

  // response side: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_stall     <= 0;
    end else if (rx_hold) begin
      rsp_ch.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_stall     <= rx_stall - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) rx_stall <= idle_len();
    end
  end

  task automatic flag_error(string what, anim_rsp_t want, anim_rsp_t got);
    string exp_s;
    n_err++;
    if (n_err <= 10) begin
      exp_s = $sformatf("st=%0d id=%0d act=%0b row=%h col=%h fr=%0d",
                        want.status, want.slot_id, want.is_active,
                        want.cur_row, want.cur_col, want.cur_frame);
      $display("%s: exp %s | got st=%0d id=%0d act=%0b row=%h col=%h fr=%0d",
               what, exp_s, got.status, got.slot_id, got.is_active,
               got.cur_row, got.cur_col, got.cur_frame);
    end
  endtask

  always @(posedge clk) begin : check_rsp
    anim_rsp_t want;
    anim_rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.status, rsp_ch.slot_id, rsp_ch.is_active, rsp_ch.cur_row,
             rsp_ch.cur_col, rsp_ch.cur_frame};
      if (exp_rsp_q.size() == 0) begin
        flag_error("response with no request pending", '0, got);
      end else begin
        want = exp_rsp_q.pop_front();
        if (got.status !== want.status || got.slot_id !== want.slot_id ||
            got.is_active !== want.is_active || got.cur_row !== want.cur_row ||
            got.cur_col !== want.cur_col || got.cur_frame !== want.cur_frame)
          flag_error("response mismatch", want, got);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    n_err               = 0;
    idle_on             = 1'b1;
    rx_hold             = 1'b0;
    rst                 = 1'b1;
    rsp_ch.ready        = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_TICK;
    req_ch.dt           = '0;
    req_ch.def_id       = '0;
    req_ch.slot         = '0;
    req_ch.frame_number = '0;
    req_ch.sheet_col    = '0;
    req_ch.sheet_row    = '0;
    req_ch.frame_time   = '0;
    req_ch.frame_total  = '0;
    req_ch.looping      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_idle_table();
    test_frame_writes();
    test_slot_play();
    test_table_full();
    test_random(200);
    idle_on <= 1'b0;
    test_random(80);
    idle_on <= 1'b1;
    test_backpressure();
    test_random(80);

    wait_drained();
    repeat (40) @(posedge clk);
    if (n_err == 0 && exp_rsp_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
